// File: src/tcw_pkg.sv
package tcw_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] glyph;
		logic [7:0] attribute;
		logic [10:0] cell_index;
	} req_t;

	typedef struct packed {
		logic [10:0] cursor;
		logic [15:0] cell_data;
		logic        scrolled;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic put_step;
		logic read_issue;
		logic sweep_go;
		logic sweep_copy;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_is_read;
		logic wrap;
		logic last_step;
		logic steps_left;
		logic sweep_done;
		logic out_free;
	} sts_t;

	localparam logic KIND_PUT  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [7:0] GLYPH_BS  = 8'd8;
	localparam logic [7:0] GLYPH_TAB = 8'd9;
	localparam logic [7:0] GLYPH_LF  = 8'd10;
	localparam logic [7:0] GLYPH_CR  = 8'd13;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [7:0]  DEFAULT_ATTR = 8'h07;
	localparam logic [15:0] BLANK_CELL   = 16'h0720;
	localparam logic [2:0]  TAB_SPACES   = 3'd5;

endpackage

// File: src/text_mode_character_writer.sv
// Channel  | Signals                      | Payload
// ---------+------------------------------+------------------------------------
// request  | req_valid, req_ready, req    | kind, glyph, attribute, cell_index
// response | rsp_valid, rsp_ready, rsp    | cursor, cell_data, scrolled
//
// A read passes through the registered read port of the cell store.
// A put that runs past the last cell scrolls: the row copy walks the whole store,
// one cell a cycle through the single write port.
// A tab is five puts, each of which may scroll.
// After reset the store is swept to blank; req_ready stays low meanwhile.
// A finished result waits in the output register; the next request is taken meanwhile.
module text_mode_character_writer import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: src/tcw_ctrl.sv
module tcw_ctrl import tcw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_PUT,
		S_SCROLL,
		S_FIN
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign req_ready = ready_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.sweep_go = 1'b1;
			end
			S_IDLE: begin
				cmd.load_item = req_valid & ready_q;
			end
			S_READ: begin
				cmd.read_issue = 1'b1;
			end
			S_PUT: begin
				cmd.put_step = 1'b1;
				cmd.load_out = ~sts.wrap & sts.last_step & sts.out_free;
			end
			S_SCROLL: begin
				cmd.sweep_go   = 1'b1;
				cmd.sweep_copy = 1'b1;
			end
			S_FIN: begin
				cmd.load_out = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.sweep_done) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (req_valid && ready_q) begin
						ready_q <= 1'b0;
						state_q <= sts.req_is_read ? S_READ : S_PUT;
					end
				end
				S_READ: begin
					state_q <= S_FIN;
				end
				S_PUT: begin
					if (sts.wrap) begin
						state_q <= S_SCROLL;
					end else if (!sts.last_step) begin
						state_q <= S_PUT;
					end else if (sts.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SCROLL: begin
					if (sts.sweep_done) begin
						state_q <= sts.steps_left ? S_PUT : S_FIN;
					end
				end
				S_FIN: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_CLEAR;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// File: src/tcw_datapath.sv
module tcw_datapath import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output sts_t sts,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + 1);
	localparam int COLW  = $clog2(COLUMNS);
	localparam int ROWW  = $clog2(ROWS);

	localparam logic [AW-1:0]   LAST_ROW  = AW'(CELLS - COLUMNS);
	localparam logic [AW-1:0]   LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0]   ROW_STEP  = AW'(COLUMNS);
	localparam logic [COLW-1:0] COL_LAST  = COLW'(COLUMNS - 1);
	localparam logic [ROWW-1:0] ROW_LAST  = ROWW'(ROWS - 1);

	// item
	logic        kind_q;
	logic [7:0]  glyph_q;
	logic [7:0]  attr_q;
	logic [10:0] idx_q;
	logic [2:0]  steps_q;
	logic        scrolled_q;

	// cursor kept both linear and as row/column
	logic [AW-1:0]   lin_q, lin_d;
	logic [COLW-1:0] col_q, col_d;
	logic [ROWW-1:0] row_q, row_d;

	logic        tab;
	logic [7:0]  put_glyph;
	logic [7:0]  put_attr;
	logic        wrap;
	logic        pw;
	logic [AW-1:0] pw_addr;
	logic [15:0] pw_data;
	logic        in_range;

	// sweep (clear after reset, row copy on scroll)
	logic [CW-1:0] sw_q;
	logic          sw_run;
	logic          sw_copy;
	logic [AW-1:0] sw_src;
	logic          wr_vld_s1;
	logic          wr_copy_s1;
	logic [AW-1:0] wr_addr_s1;

	// cell store
	logic [15:0]   mem [CELLS];
	logic [15:0]   rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;

	logic rsp_valid_q;
	rsp_t rsp_q;

	assign tab       = (glyph_q == GLYPH_TAB);
	assign put_glyph = tab ? CHAR_SPACE : glyph_q;
	assign put_attr  = (tab || attr_q == 8'h00) ? DEFAULT_ATTR : attr_q;
	assign in_range  = (32'(idx_q) < 32'(CELLS));

	always_comb begin
		lin_d   = lin_q;
		col_d   = col_q;
		row_d   = row_q;
		wrap    = 1'b0;
		pw      = 1'b0;
		pw_addr = lin_q;
		pw_data = {put_attr, put_glyph};
		unique case (put_glyph)
			GLYPH_BS: begin
				if (lin_q != '0) begin
					lin_d   = lin_q - 1'b1;
					pw      = 1'b1;
					pw_addr = lin_q - 1'b1;
					pw_data = {put_attr, CHAR_SPACE};
					if (col_q == '0) begin
						col_d = COL_LAST;
						row_d = row_q - 1'b1;
					end else begin
						col_d = col_q - 1'b1;
					end
				end
			end
			GLYPH_LF: begin
				if (row_q == ROW_LAST) begin
					wrap = 1'b1;
				end else begin
					row_d = row_q + 1'b1;
					col_d = '0;
					lin_d = lin_q - AW'(col_q) + ROW_STEP;
				end
			end
			GLYPH_CR: begin
				col_d = '0;
				lin_d = lin_q - AW'(col_q);
			end
			default: begin
				pw = 1'b1;
				if (col_q == COL_LAST) begin
					if (row_q == ROW_LAST) begin
						wrap = 1'b1;
					end else begin
						row_d = row_q + 1'b1;
						col_d = '0;
						lin_d = lin_q + 1'b1;
					end
				end else begin
					col_d = col_q + 1'b1;
					lin_d = lin_q + 1'b1;
				end
			end
		endcase
		// past the end: cursor lands on the start of the bottom row
		if (wrap) begin
			lin_d = LAST_ROW;
			col_d = '0;
			row_d = ROW_LAST;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q  <= req.kind;
			glyph_q <= req.glyph;
			attr_q  <= req.attribute;
			idx_q   <= req.cell_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q    <= '0;
			scrolled_q <= 1'b0;
			lin_q      <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (cmd.load_item) begin
			steps_q    <= (req.kind == KIND_PUT && req.glyph == GLYPH_TAB) ? TAB_SPACES : 3'd1;
			scrolled_q <= 1'b0;
		end else if (cmd.put_step) begin
			steps_q    <= steps_q - 1'b1;
			scrolled_q <= scrolled_q | wrap;
			lin_q      <= lin_d;
			col_q      <= col_d;
			row_q      <= row_d;
		end
	end

	// sweep: read source row ahead, write one cell a cycle from the s1 stage
	assign sw_run  = cmd.sweep_go && (sw_q < CW'(CELLS));
	assign sw_copy = cmd.sweep_copy && (sw_q < CW'(CELLS - COLUMNS));
	assign sw_src  = sw_q[AW-1:0] + ROW_STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q      <= '0;
			wr_vld_s1 <= 1'b0;
		end else if (!cmd.sweep_go) begin
			sw_q      <= '0;
			wr_vld_s1 <= 1'b0;
		end else begin
			if (sw_run) begin
				sw_q <= sw_q + 1'b1;
			end
			wr_vld_s1 <= sw_run;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= sw_q[AW-1:0];
		wr_copy_s1 <= sw_copy;
	end

	assign mem_we    = wr_vld_s1 | (cmd.put_step & pw);
	assign mem_waddr = wr_vld_s1 ? wr_addr_s1 : pw_addr;
	assign mem_wdata = wr_vld_s1 ? (wr_copy_s1 ? rdata_q : BLANK_CELL) : pw_data;
	assign mem_re    = cmd.read_issue | (sw_run & sw_copy);
	assign mem_raddr = cmd.read_issue ? AW'(idx_q) : sw_src;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.cursor    <= 11'(cmd.put_step ? lin_d : lin_q);
			rsp_q.cell_data <= (kind_q == KIND_READ && in_range) ? rdata_q : 16'h0000;
			rsp_q.scrolled  <= scrolled_q | (cmd.put_step & wrap);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign sts.req_is_read = (req.kind == KIND_READ);
	assign sts.wrap        = wrap;
	assign sts.last_step   = (steps_q == 3'd1);
	assign sts.steps_left  = (steps_q != 3'd0);
	assign sts.sweep_done  = wr_vld_s1 && (wr_addr_s1 == LAST_CELL);
	assign sts.out_free    = ~rsp_valid_q | rsp_ready;

endmodule

// File: src/tcw_checker.sv
module tcw_checker import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	localparam int CELLS = COLUMNS * ROWS;

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (CELLS > 2048) || (32'(rsp.cursor) < 32'(CELLS)))
		else $error("cursor beyond screen");

	// nonzero cell data only comes from reads, which never scroll
	a_read_no_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.cell_data != 16'h0000) |-> !rsp.scrolled)
		else $error("read reported a scroll");

	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.scrolled |->
			(CELLS > 2048) || (32'(rsp.cursor) >= 32'(CELLS - COLUMNS)))
		else $error("cursor not on bottom row after scroll");

endmodule

bind text_mode_character_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
